/* rtl/binary_trie_max_xor_macros.svh */
// Assertion macros for the binary trie max-xor checker.
// Expects clk and arst_n in the scope that uses them.
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BTMX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btmx checker: same-cycle property failed");

// next-cycle implication, disabled during reset
`define BTMX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btmx checker: next-cycle property failed");

`endif

/* rtl/btmx_pkg.sv */
// Shared types, constants and codes for the binary trie max-xor block.
// No dependencies; used by every module of the block.
package btmx_pkg;

	localparam int KEY_BITS   = 31;
	localparam int NODE_COUNT = 4096;
	localparam int COUNT_BITS = 20;

	// fixed field widths of the item interface
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int KEY_W    = 31;

	localparam int NODE_AW = $clog2(NODE_COUNT);
	localparam int NF_W    = $clog2(NODE_COUNT + 1);
	localparam int LVL_W   = $clog2(KEY_BITS);
	localparam int INIT_W  = $clog2(KEY_BITS + 1);

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd2;
	localparam logic [MODE_W-1:0] MODE_XOR    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [KEY_W-1:0]    best_xor;
	} rsp_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count1;
		logic [COUNT_BITS-1:0] count0;
		logic [NODE_AW-1:0]    child1;
		logic [NODE_AW-1:0]    child0;
	} node_t;

	typedef enum logic [1:0] {
		OP_INS,
		OP_CHK,
		OP_DEC,
		OP_XOR
	} walk_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_INS,
		ST_CHK,
		ST_DEC,
		ST_XOR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                start;
		logic                restart;
		logic                step;
		walk_op_t            op;
		logic                init_step;
		logic                load_out;
		logic [STATUS_W-1:0] code;
		logic                found;
		logic                use_res;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic dead;
		logic at_root;
		logic init_last;
	} stat_t;

endpackage

/* rtl/btmx_ctrl.sv */
// Controller state machine of the binary trie max-xor block.
// Depends on btmx_pkg; drives the datapath through cmd_t, reads stat_t.
module btmx_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [btmx_pkg::MODE_W-1:0] req_mode,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  btmx_pkg::stat_t           stat,
	output btmx_pkg::cmd_t            cmd
);

	btmx_pkg::state_t state_q, state_d;
	logic                          erase_q, erase_d;
	logic                          clr_q, clr_d;
	logic [btmx_pkg::STATUS_W-1:0] code_q, code_d;
	logic                          found_q, found_d;
	logic                          use_q, use_d;
	logic                          out_valid_q;
	logic                          accept;

	assign req_stall = (state_q != btmx_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btmx_pkg::ST_INIT;
			erase_q <= 1'b0;
			clr_q   <= 1'b0;
			code_q  <= btmx_pkg::STATUS_OK;
			found_q <= 1'b0;
			use_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			erase_q <= erase_d;
			clr_q   <= clr_d;
			code_q  <= code_d;
			found_q <= found_d;
			use_q   <= use_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		erase_d = erase_q;
		clr_d   = clr_q;
		code_d  = code_q;
		found_d = found_q;
		use_d   = use_q;
		cmd           = '0;
		cmd.op        = btmx_pkg::OP_CHK;
		cmd.code      = code_q;
		cmd.found     = found_q;
		cmd.use_res   = use_q;
		case (state_q)
			btmx_pkg::ST_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) begin
					if (clr_q) begin
						clr_d   = 1'b0;
						state_d = btmx_pkg::ST_EMIT;
					end else begin
						state_d = btmx_pkg::ST_IDLE;
					end
				end
			end
			btmx_pkg::ST_IDLE: begin
				if (accept) begin
					code_d  = btmx_pkg::STATUS_OK;
					found_d = 1'b0;
					use_d   = 1'b0;
					case (req_mode)
						btmx_pkg::MODE_INSERT: begin
							if (stat.full) begin
								code_d  = btmx_pkg::STATUS_FULL;
								state_d = btmx_pkg::ST_EMIT;
							end else begin
								cmd.start = 1'b1;
								state_d   = btmx_pkg::ST_INS;
							end
						end
						btmx_pkg::MODE_ERASE: begin
							cmd.start = 1'b1;
							erase_d   = 1'b1;
							state_d   = btmx_pkg::ST_CHK;
						end
						btmx_pkg::MODE_SEARCH: begin
							cmd.start = 1'b1;
							erase_d   = 1'b0;
							state_d   = btmx_pkg::ST_CHK;
						end
						btmx_pkg::MODE_XOR: begin
							cmd.start = 1'b1;
							use_d     = 1'b1;
							state_d   = btmx_pkg::ST_XOR;
						end
						btmx_pkg::MODE_CLEAR: begin
							clr_d   = 1'b1;
							state_d = btmx_pkg::ST_INIT;
						end
						default: begin
							state_d = btmx_pkg::ST_EMIT;
						end
					endcase
				end
			end
			btmx_pkg::ST_INS: begin
				cmd.step = 1'b1;
				cmd.op   = btmx_pkg::OP_INS;
				if (stat.last) begin
					state_d = btmx_pkg::ST_EMIT;
				end
			end
			btmx_pkg::ST_CHK: begin
				cmd.step = 1'b1;
				cmd.op   = btmx_pkg::OP_CHK;
				if (stat.dead) begin
					code_d  = erase_q ? btmx_pkg::STATUS_NOT_FOUND : btmx_pkg::STATUS_OK;
					state_d = btmx_pkg::ST_EMIT;
				end else if (stat.last) begin
					if (erase_q) begin
						// path verified: walk again from the root and decrement
						cmd.restart = 1'b1;
						state_d     = btmx_pkg::ST_DEC;
					end else begin
						found_d = 1'b1;
						state_d = btmx_pkg::ST_EMIT;
					end
				end
			end
			btmx_pkg::ST_DEC: begin
				cmd.step = 1'b1;
				cmd.op   = btmx_pkg::OP_DEC;
				if (stat.last) begin
					state_d = btmx_pkg::ST_EMIT;
				end
			end
			btmx_pkg::ST_XOR: begin
				cmd.step = 1'b1;
				cmd.op   = btmx_pkg::OP_XOR;
				if (stat.dead) begin
					// no live edge at the root means an empty trie
					code_d  = stat.at_root ? btmx_pkg::STATUS_NOT_FOUND : btmx_pkg::STATUS_OK;
					state_d = btmx_pkg::ST_EMIT;
				end else if (stat.last) begin
					state_d = btmx_pkg::ST_EMIT;
				end
			end
			btmx_pkg::ST_EMIT: begin
				if (!out_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = btmx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = btmx_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/btmx_dpath.sv */
// Datapath of the binary trie max-xor block: node store, walk registers,
// allocator and result register. Depends on btmx_pkg; controlled by btmx_ctrl.
module btmx_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [btmx_pkg::KEY_W-1:0] req_key,
	input  btmx_pkg::cmd_t             cmd,
	output btmx_pkg::stat_t            stat,
	output btmx_pkg::rsp_t             rsp
);

	localparam logic [btmx_pkg::LVL_W-1:0] LVL_TOP =
		btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
	localparam logic [btmx_pkg::NF_W-1:0] NF_RESET =
		btmx_pkg::NF_W'(btmx_pkg::KEY_BITS + 1);
	localparam logic [btmx_pkg::NF_W-1:0] NF_LIMIT =
		btmx_pkg::NF_W'(btmx_pkg::NODE_COUNT - btmx_pkg::KEY_BITS);
	localparam logic [btmx_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

	btmx_pkg::node_t mem [btmx_pkg::NODE_COUNT];
	btmx_pkg::node_t rd_q;

	logic [btmx_pkg::KEY_BITS-1:0] key_q;
	logic [btmx_pkg::NODE_AW-1:0]  cur_q;
	logic [btmx_pkg::LVL_W-1:0]    lvl_q;
	logic [btmx_pkg::KEY_BITS-1:0] res_q;
	logic                          new_q;
	logic [btmx_pkg::NF_W-1:0]     next_free_q;
	logic [btmx_pkg::INIT_W-1:0]   init_q;

	btmx_pkg::node_t                node, wnode, init_node;
	logic                           b;
	logic [btmx_pkg::NODE_AW-1:0]   child_b, child_t, nxt;
	logic [btmx_pkg::COUNT_BITS-1:0] cnt_b, cnt_t, cnt_new;
	logic                           live_b, live_t, alloc, take_t;
	logic                           we;
	logic [btmx_pkg::NODE_AW-1:0]   wa, rd_addr;
	btmx_pkg::node_t                wd;

	// a freshly allocated node is all zero and is never read from the store
	assign node    = new_q ? '0 : rd_q;
	assign b       = key_q[lvl_q];
	assign child_b = b ? node.child1 : node.child0;
	assign child_t = b ? node.child0 : node.child1;
	assign cnt_b   = b ? node.count1 : node.count0;
	assign cnt_t   = b ? node.count0 : node.count1;
	assign live_b  = (child_b != '0) && (cnt_b != '0);
	assign live_t  = (child_t != '0) && (cnt_t != '0);
	assign alloc   = (child_b == '0);
	assign take_t  = (cmd.op == btmx_pkg::OP_XOR) && live_t;

	always_comb begin
		nxt     = child_b;
		cnt_new = cnt_b;
		case (cmd.op)
			btmx_pkg::OP_INS: begin
				nxt     = alloc ? next_free_q[btmx_pkg::NODE_AW-1:0] : child_b;
				cnt_new = (cnt_b == CNT_MAX) ? cnt_b : cnt_b + 1'b1;
			end
			btmx_pkg::OP_DEC: begin
				cnt_new = cnt_b - 1'b1;
			end
			btmx_pkg::OP_XOR: begin
				nxt = live_t ? child_t : child_b;
			end
			default: begin
				nxt = child_b;
			end
		endcase
		wnode = node;
		if (b) begin
			wnode.child1 = nxt;
			wnode.count1 = cnt_new;
		end else begin
			wnode.child0 = nxt;
			wnode.count0 = cnt_new;
		end
	end

	always_comb begin
		init_node = '0;
		if (init_q != btmx_pkg::INIT_W'(btmx_pkg::KEY_BITS)) begin
			init_node.child0 = btmx_pkg::NODE_AW'(init_q) + 1'b1;
			init_node.count0 = btmx_pkg::COUNT_BITS'(1);
		end
	end

	assign stat.full      = (next_free_q > NF_LIMIT);
	assign stat.last      = (lvl_q == '0);
	assign stat.at_root   = (lvl_q == LVL_TOP);
	assign stat.init_last = (init_q == btmx_pkg::INIT_W'(btmx_pkg::KEY_BITS));
	assign stat.dead      = (cmd.op == btmx_pkg::OP_XOR) ? (!live_t && !live_b) : !live_b;

	always_comb begin
		we = 1'b0;
		wa = cur_q;
		wd = wnode;
		if (cmd.init_step) begin
			we = 1'b1;
			wa = btmx_pkg::NODE_AW'(init_q);
			wd = init_node;
		end else if (cmd.step && (cmd.op == btmx_pkg::OP_INS || cmd.op == btmx_pkg::OP_DEC)) begin
			we = 1'b1;
		end
	end

	// next node read is issued in the same cycle the current level resolves;
	// a restart goes back to the root
	assign rd_addr = (cmd.step && !cmd.restart) ? nxt : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= NF_RESET;
			init_q      <= '0;
			new_q       <= 1'b0;
		end else begin
			if (cmd.init_step) begin
				if (stat.init_last) begin
					init_q      <= '0;
					next_free_q <= NF_RESET;
				end else begin
					init_q <= init_q + 1'b1;
				end
			end
			if (cmd.start || cmd.restart) begin
				new_q <= 1'b0;
			end else if (cmd.step) begin
				new_q <= (cmd.op == btmx_pkg::OP_INS) && alloc;
				if ((cmd.op == btmx_pkg::OP_INS) && alloc) begin
					next_free_q <= next_free_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= req_key[btmx_pkg::KEY_BITS-1:0];
		end
		if (cmd.start || cmd.restart) begin
			cur_q <= '0;
			lvl_q <= LVL_TOP;
			res_q <= '0;
		end else if (cmd.step) begin
			cur_q <= nxt;
			lvl_q <= lvl_q - 1'b1;
			if (take_t) begin
				res_q[lvl_q] <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			rsp.status   <= cmd.code;
			rsp.found    <= cmd.found;
			rsp.best_xor <= cmd.use_res ? btmx_pkg::KEY_W'(res_q) : '0;
		end
	end

endmodule

/* rtl/binary_trie_max_xor.sv */
// Binary trie max-xor block: a multiset of keys in a node store with insert,
// erase, search, max-xor query and clear. An item walks the trie one level per
// cycle, limited by the single read port of the node store whose registered
// read data feeds the next address. An erase walks twice, a check pass and an
// update pass; an insert refused as full or an unused mode skips the walk and
// goes straight to its result. Clear and reset run an initialization pass that
// rebuilds the zero-key path; input stalls during it. The result register lets
// the next item be accepted while a result still waits to be taken; that item
// holds its own result until the register frees up, which adds the wait to its
// time.
module binary_trie_max_xor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  btmx_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output btmx_pkg::rsp_t   rsp
);

	btmx_pkg::cmd_t  cmd;
	btmx_pkg::stat_t stat;

	btmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_mode  (req.mode),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	btmx_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_key (req.key_value),
		.cmd     (cmd),
		.stat    (stat),
		.rsp     (rsp)
	);

endmodule

/* rtl/btmx_checker.sv */
// Port-level checker for the binary trie max-xor block, bound to the top level.
// Depends on btmx_pkg and binary_trie_max_xor_macros.svh.
`include "binary_trie_max_xor_macros.svh"

module btmx_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input btmx_pkg::rsp_t rsp
);

	// a stalled result holds
	`BTMX_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one item at a time: an accepted item makes the block busy
	`BTMX_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

	// found comes only with an ok status
	`BTMX_ASSERT_NOW(a_found_ok, rsp_valid && rsp.found, rsp.status == btmx_pkg::STATUS_OK)

	// a nonzero xor comes only from a successful query
	`BTMX_ASSERT_NOW(a_xor_ok, rsp_valid && (rsp.best_xor != '0),
		(rsp.status == btmx_pkg::STATUS_OK) && !rsp.found)

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (.*);
